### hw/rtl/mnes_pkg.sv
// Shared types and constants for the note event scheduler.
package mnes_pkg;

    localparam int EVENT_SLOTS_DEF = 32;
    localparam int TIME_BITS_DEF   = 24;

    localparam logic [7:0] MSG_ON  = 8'h90;
    localparam logic [7:0] MSG_OFF = 8'h80;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] start_ms;
        logic [4:0]  chan_num;
        logic [6:0]  key;
        logic [6:0]  strike;
        logic [15:0] length_ms;
    } sched_in_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_key;
        logic [6:0] data_velocity;
        logic       last_of_tick;
    } sched_out_t;

    typedef struct packed {
        logic [3:0]  chan;
        logic [6:0]  key;
        logic [6:0]  vel;
        logic [15:0] len;
    } ev_info_t;

    typedef struct packed {
        logic [3:0] chan;
        logic [6:0] key;
    } act_info_t;

    typedef struct packed {
        logic take_prev;
        logic take_new;
    } ev_ctl_t;

    typedef struct packed {
        logic shift;
        logic load;
    } act_ctl_t;

endpackage

### hw/rtl/mnes_event_cell.sv
// One slot of the time-sorted event table; shifts up from its lower neighbor on insert.
module mnes_event_cell #(
    parameter int TIME_BITS = mnes_pkg::TIME_BITS_DEF
) (
    input  logic                     clk,
    input  mnes_pkg::ev_ctl_t        ctl,
    input  logic                     in_range,
    input  logic [TIME_BITS-1:0]     new_start,
    input  mnes_pkg::ev_info_t       new_info,
    input  logic [TIME_BITS-1:0]     prev_start,
    input  mnes_pkg::ev_info_t       prev_info,
    output logic [TIME_BITS-1:0]     start,
    output mnes_pkg::ev_info_t       info,
    output logic                     later
);
    import mnes_pkg::*;

    logic [TIME_BITS-1:0] start_reg;
    ev_info_t             info_reg;

    // This slot holds a pending event that must move past the new one.
    assign later = in_range && (start_reg > new_start);
    assign start = start_reg;
    assign info  = info_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.take_prev)
        begin
            start_reg <= prev_start;
            info_reg  <= prev_info;
        end
        else if (ctl.take_new)
        begin
            start_reg <= new_start;
            info_reg  <= new_info;
        end
    end

endmodule

### hw/rtl/mnes_active_cell.sv
// One slot of the sounding-note queue; shifts toward the head during a retire pass.
module mnes_active_cell #(
    parameter int TIME_BITS = mnes_pkg::TIME_BITS_DEF
) (
    input  logic                     clk,
    input  mnes_pkg::act_ctl_t       ctl,
    input  logic [TIME_BITS-1:0]     load_end,
    input  mnes_pkg::act_info_t      load_info,
    input  logic [TIME_BITS-1:0]     nbr_end,
    input  mnes_pkg::act_info_t      nbr_info,
    output logic [TIME_BITS-1:0]     end_ms,
    output mnes_pkg::act_info_t      info
);
    import mnes_pkg::*;

    logic [TIME_BITS-1:0] end_reg;
    act_info_t            info_reg;

    assign end_ms = end_reg;
    assign info   = info_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            end_reg  <= load_end;
            info_reg <= load_info;
        end
        else if (ctl.shift)
        begin
            end_reg  <= nbr_end;
            info_reg <= nbr_info;
        end
    end

endmodule

### hw/rtl/midi_note_event_scheduler_unit.sv
// Top level of the note event scheduler: command decode, tick sequencer and output register.
// Add, clear and ignored commands complete without leaving idle. A tick steps the note
// queue to retire due notes, steps the event table to start due events, steps the note queue
// again, then flushes the held message; each pass takes one entry per cycle unless the
// output stalls.
// Throughput: one item at a time; a new command is taken once the previous tick is done.
// Reset: rst_n is asynchronous and active low; it empties both tables and zeroes time.
module midi_note_event_scheduler_unit #(
    parameter int EVENT_SLOTS = mnes_pkg::EVENT_SLOTS_DEF,
    parameter int TIME_BITS   = mnes_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mnes_pkg::sched_in_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mnes_pkg::sched_out_t out_data
);
    import mnes_pkg::*;

    localparam int CW = $clog2(EVENT_SLOTS + 1);
    localparam int IW = $clog2(EVENT_SLOTS);
    localparam logic [CW-1:0] SLOTS_C = CW'(EVENT_SLOTS);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // The tick sequencer walks three phases: retire due notes, start due events,
    // retire again (catches zero-length notes), then flushes the held message.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RET1  = 5'b00010,
        ST_ON    = 5'b00100,
        ST_RET2  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] ev_count_reg, ev_count_next;
    logic [CW-1:0] next_ev_reg, next_ev_next;
    logic [CW-1:0] act_n_reg, act_n_next;
    logic [CW-1:0] iter_reg, iter_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    // One message is held back so that the last one of a tick can be flagged.
    logic       pend_v_reg, pend_v_next;
    sched_out_t pend_reg, pend_next;
    logic       out_v_reg, out_v_next;
    sched_out_t out_reg, out_next;

    // Event table cells.
    logic [TIME_BITS-1:0] ev_start [EVENT_SLOTS];
    ev_info_t             ev_info  [EVENT_SLOTS];
    logic                 ev_later [EVENT_SLOTS];
    ev_ctl_t              ev_ctl   [EVENT_SLOTS];

    // Sounding-note queue cells; entry zero is the head.
    logic [TIME_BITS-1:0] act_end  [EVENT_SLOTS];
    act_info_t            act_info [EVENT_SLOTS];
    act_ctl_t             act_ctl  [EVENT_SLOTS];

    logic                 add_en;
    logic [TIME_BITS-1:0] new_start;
    ev_info_t             new_info;

    logic                 rot_step;
    logic                 rot_keep;
    logic                 app_en;
    logic [TIME_BITS-1:0] app_end;
    act_info_t            app_info;

    logic                 can_emit;
    logic                 emit;
    sched_out_t           emit_msg;

    logic [TIME_BITS-1:0] cur_start;
    ev_info_t             cur_info;
    logic                 ev_due;
    logic                 head_due;
    logic [TIME_BITS:0]   end_sum;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // Saturate the requested start time to the time range of the counter.
    always_comb
    begin
        if ({8'd0, in_data.start_ms} > 32'(TIME_MAX))
        begin
            new_start = TIME_MAX;
        end
        else
        begin
            new_start = TIME_BITS'({8'd0, in_data.start_ms});
        end
        new_info.chan = in_data.chan_num[3:0] - 4'd1;
        new_info.key  = in_data.key;
        new_info.vel  = in_data.strike;
        new_info.len  = in_data.length_ms;
    end

    assign add_en = in_valid && in_ready && (in_data.cmd == CMD_ADD)
                    && (ev_count_reg < SLOTS_C);

    genvar gi;
    generate
        for (gi = 0; gi < EVENT_SLOTS; gi++)
        begin : g_ev
            logic in_rng;
            logic prev_later;
            logic [TIME_BITS-1:0] p_start;
            ev_info_t p_info;

            assign in_rng = (CW'(gi) >= next_ev_reg) && (CW'(gi) < ev_count_reg);
            if (gi == 0)
            begin : g_first
                assign prev_later = 1'b0;
                assign p_start    = ev_start[0];
                assign p_info     = ev_info[0];
            end
            else
            begin : g_rest
                assign prev_later = ev_later[gi-1];
                assign p_start    = ev_start[gi-1];
                assign p_info     = ev_info[gi-1];
            end

            // Pending events are sorted, so the later flags form one run at the top.
            assign ev_ctl[gi].take_prev = add_en && prev_later;
            assign ev_ctl[gi].take_new  = add_en && !prev_later
                                          && (CW'(gi) >= next_ev_reg)
                                          && (CW'(gi) <= ev_count_reg)
                                          && ((CW'(gi) == ev_count_reg) || ev_later[gi]);

            mnes_event_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .clk       (clk),
                .ctl       (ev_ctl[gi]),
                .in_range  (in_rng),
                .new_start (new_start),
                .new_info  (new_info),
                .prev_start(p_start),
                .prev_info (p_info),
                .start     (ev_start[gi]),
                .info      (ev_info[gi]),
                .later     (ev_later[gi])
            );
        end

        for (gi = 0; gi < EVENT_SLOTS; gi++)
        begin : g_act
            logic [TIME_BITS-1:0] n_end;
            act_info_t n_info;
            logic [TIME_BITS-1:0] l_end;
            act_info_t l_info;
            logic rot_here;

            if (gi == EVENT_SLOTS - 1)
            begin : g_last
                assign n_end  = act_end[gi];
                assign n_info = act_info[gi];
            end
            else
            begin : g_mid
                assign n_end  = act_end[gi+1];
                assign n_info = act_info[gi+1];
            end

            // A kept head note moves to the tail slot of the current queue.
            assign rot_here = rot_step && rot_keep && (CW'(gi) + CW'(1) == act_n_reg);
            assign act_ctl[gi].shift = rot_step;
            assign act_ctl[gi].load  = rot_here || (app_en && (CW'(gi) == act_n_reg));
            assign l_end  = rot_here ? act_end[0] : app_end;
            assign l_info = rot_here ? act_info[0] : app_info;

            mnes_active_cell #(
                .TIME_BITS(TIME_BITS)
            ) u_cell (
                .clk      (clk),
                .ctl      (act_ctl[gi]),
                .load_end (l_end),
                .load_info(l_info),
                .nbr_end  (n_end),
                .nbr_info (n_info),
                .end_ms   (act_end[gi]),
                .info     (act_info[gi])
            );
        end
    endgenerate

    // Event at the play pointer and its end time.
    assign cur_start = ev_start[next_ev_reg[IW-1:0]];
    assign cur_info  = ev_info[next_ev_reg[IW-1:0]];
    assign ev_due    = (next_ev_reg < ev_count_reg) && (cur_start <= now_reg);
    assign end_sum   = {1'b0, cur_start} + (TIME_BITS+1)'(cur_info.len);
    assign app_end   = end_sum[TIME_BITS] ? TIME_MAX : end_sum[TIME_BITS-1:0];
    assign app_info.chan = cur_info.chan;
    assign app_info.key  = cur_info.key;

    assign head_due = (act_end[0] <= now_reg);
    assign can_emit = !pend_v_reg || !out_v_reg || out_ready;

    always_comb
    begin
        rot_step = 1'b0;
        rot_keep = 1'b0;
        app_en   = 1'b0;
        emit     = 1'b0;
        emit_msg = '0;
        if ((state_reg == ST_RET1 || state_reg == ST_RET2) && (iter_reg != '0))
        begin
            rot_keep = !head_due;
            rot_step = !head_due || can_emit;
            emit     = head_due && can_emit;
            emit_msg.status_byte   = MSG_OFF | {4'd0, act_info[0].chan};
            emit_msg.data_key      = act_info[0].key;
            emit_msg.data_velocity = 7'd0;
        end
        else if (state_reg == ST_ON && ev_due && can_emit)
        begin
            emit   = 1'b1;
            app_en = (act_n_reg < SLOTS_C);
            emit_msg.status_byte   = MSG_ON | {4'd0, cur_info.chan};
            emit_msg.data_key      = cur_info.key;
            emit_msg.data_velocity = cur_info.vel;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ev_count_next = ev_count_reg;
        next_ev_next  = next_ev_reg;
        act_n_next    = act_n_reg;
        iter_next     = iter_reg;
        now_next      = now_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        out_v_next    = out_v_reg && !out_ready;
        out_next      = out_reg;

        // A new message pushes the held one out, flagged as not last.
        if (emit)
        begin
            if (pend_v_reg)
            begin
                out_v_next = 1'b1;
                out_next   = pend_reg;
                out_next.last_of_tick = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_next   = emit_msg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.cmd)
                        CMD_ADD:
                        begin
                            if (add_en)
                            begin
                                ev_count_next = ev_count_reg + CW'(1);
                            end
                        end
                        CMD_TICK:
                        begin
                            iter_next  = act_n_reg;
                            state_next = ST_RET1;
                        end
                        CMD_CLEAR:
                        begin
                            ev_count_next = '0;
                            next_ev_next  = '0;
                            act_n_next    = '0;
                            now_next      = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RET1, ST_RET2:
            begin
                if (iter_reg == '0)
                begin
                    if (state_reg == ST_RET1)
                    begin
                        state_next = ST_ON;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else if (rot_step)
                begin
                    iter_next = iter_reg - CW'(1);
                    if (!rot_keep)
                    begin
                        act_n_next = act_n_reg - CW'(1);
                    end
                end
            end
            ST_ON:
            begin
                if (!ev_due)
                begin
                    iter_next  = act_n_reg;
                    state_next = ST_RET2;
                end
                else if (emit)
                begin
                    next_ev_next = next_ev_reg + CW'(1);
                    if (app_en)
                    begin
                        act_n_next = act_n_reg + CW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_v_reg || !out_v_reg || out_ready)
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next = 1'b1;
                        out_next   = pend_reg;
                        out_next.last_of_tick = 1'b1;
                    end
                    pend_v_next = 1'b0;
                    if (now_reg != TIME_MAX)
                    begin
                        now_next = now_reg + TIME_BITS'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ev_count_reg <= '0;
            next_ev_reg  <= '0;
            act_n_reg    <= '0;
            iter_reg     <= '0;
            now_reg      <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ev_count_reg <= ev_count_next;
            next_ev_reg  <= next_ev_next;
            act_n_reg    <= act_n_next;
            iter_reg     <= iter_next;
            now_reg      <= now_next;
            pend_v_reg   <= pend_v_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule
